// ===== design/fractional_lif_neuron_step_top_macros.svh =====
// assertion helpers for the fractional lif neuron block
`ifndef FRACTIONAL_LIF_NEURON_STEP_TOP_MACROS_SVH
`define FRACTIONAL_LIF_NEURON_STEP_TOP_MACROS_SVH

// same-cycle implication
`define FLIF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FLIF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/flif_pkg.sv =====
// ----------------------------------------------------------------------------
// flif_pkg
// shared constants, codes and control types of the fractional lif neuron
// ----------------------------------------------------------------------------
`default_nettype none

package flif_pkg;

	localparam int DATA_W         = 32;
	localparam int HIST_DEPTH_DEF = 256;
	localparam int ACC_W          = 56;
	localparam int PROD_W         = 65;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HLEN  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAK  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INGN  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REST  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_THR   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RPOT  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REFR  = 4'd7;

	// register reset values
	localparam logic [16:0]              ALPHA_RST = 17'd52429;
	localparam logic [8:0]               HLEN_RST  = 9'd256;
	localparam logic [30:0]              LEAK_RST  = 31'd655;
	localparam logic [30:0]              INGN_RST  = 31'd65536;
	localparam logic signed [DATA_W-1:0] REST_RST  = 32'sd0;
	localparam logic signed [DATA_W-1:0] THR_RST   = 32'sd65536;
	localparam logic signed [DATA_W-1:0] RPOT_RST  = 32'sd0;
	localparam logic [15:0]              REFR_RST  = 16'd0;

	// 1.0 in the alpha format
	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	// product kinds on the shared multiplier
	localparam logic [1:0] KIND_INPUT = 2'd0;
	localparam logic [1:0] KIND_LEAK  = 2'd1;
	localparam logic [1:0] KIND_HIST  = 2'd2;

	typedef struct packed {
		logic       in_load;
		logic       hist_push;
		logic       acc_clear;
		logic       issue;
		logic [1:0] kind;
		logic       commit_step;
		logic       commit_refr;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic refractory;
		logic out_free;
	} dp_stat_t;

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
		lo = ~hi;
		if (a > hi) begin
			sat_data = hi[DATA_W-1:0];
		end else if (a < lo) begin
			sat_data = lo[DATA_W-1:0];
		end else begin
			sat_data = a[DATA_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/flif_wgen.sv =====
// ----------------------------------------------------------------------------
// flif_wgen
// builds the grunwald-letnikov weight table from alpha, one weight at a time
// ----------------------------------------------------------------------------
`default_nettype none

module flif_wgen #(
	parameter int HISTORY_DEPTH = flif_pkg::HIST_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [16:0]                   alpha,
	output logic                               busy,
	output logic                               w_we,
	output logic [$clog2(HISTORY_DEPTH)-1:0]   w_addr,
	output logic signed [flif_pkg::DATA_W-1:0] w_data
);

	localparam int T     = HISTORY_DEPTH - 1;
	localparam int TW    = $clog2(HISTORY_DEPTH);
	localparam int NUM_W = TW + 18;
	localparam int C_W   = flif_pkg::DATA_W;
	localparam int P_W   = C_W + NUM_W;
	localparam int Y_W   = P_W - 15;
	localparam int DC_W  = $clog2(Y_W);

	localparam logic [2:0] W_INIT  = 3'd0;
	localparam logic [2:0] W_MUL   = 3'd1;
	localparam logic [2:0] W_PREP  = 3'd2;
	localparam logic [2:0] W_DIV   = 3'd3;
	localparam logic [2:0] W_WRITE = 3'd4;
	localparam logic [2:0] W_IDLE  = 3'd5;

	logic [2:0]              state_q;
	logic signed [C_W-1:0]   c_q;
	logic signed [NUM_W-1:0] num_q;
	logic [TW-1:0]           j_q;
	logic signed [P_W-1:0]   p_q;
	logic                    neg_q;
	logic [Y_W-1:0]          y_q;
	logic [TW-1:0]           rem_q;
	logic [DC_W-1:0]         dcnt_q;

	logic signed [P_W-1:0]   p_d;
	logic [P_W-1:0]          mag;
	logic [P_W:0]            x_sum;
	logic [TW:0]             trial;
	logic                    qbit;
	logic signed [C_W-1:0]   c_new;

	assign p_d   = c_q * num_q;
	assign mag   = p_q[P_W-1] ? P_W'(-p_q) : P_W'(p_q);
	// rounding half of the divisor j*65536, then the exact factor 65536 goes as a shift
	assign x_sum = {1'b0, mag} + ((P_W+1)'(j_q) << 15);
	assign trial = {rem_q, y_q[Y_W-1]};
	assign qbit  = (trial >= {1'b0, j_q});
	assign c_new = neg_q ? -signed'(y_q[C_W-1:0]) : signed'(y_q[C_W-1:0]);

	assign busy   = (state_q != W_IDLE);
	assign w_we   = (state_q == W_WRITE);
	assign w_addr = j_q - 1'b1;
	assign w_data = c_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_INIT;
			c_q     <= '0;
			num_q   <= '0;
			j_q     <= '0;
			p_q     <= '0;
			neg_q   <= 1'b0;
			y_q     <= '0;
			rem_q   <= '0;
			dcnt_q  <= '0;
		end else if (start) begin
			state_q <= W_INIT;
		end else begin
			case (state_q)
				W_INIT: begin
					c_q     <= C_W'(64'sd1 << 30);
					num_q   <= -signed'(NUM_W'(alpha));
					j_q     <= TW'(1);
					state_q <= W_MUL;
				end
				W_MUL: begin
					p_q     <= p_d;
					state_q <= W_PREP;
				end
				W_PREP: begin
					neg_q   <= p_q[P_W-1];
					y_q     <= x_sum[P_W:16];
					rem_q   <= '0;
					dcnt_q  <= DC_W'(Y_W - 1);
					state_q <= W_DIV;
				end
				W_DIV: begin
					// restoring division, one quotient bit a cycle
					rem_q  <= qbit ? TW'(trial - {1'b0, j_q}) : trial[TW-1:0];
					y_q    <= {y_q[Y_W-2:0], qbit};
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) begin
						state_q <= W_WRITE;
					end
				end
				W_WRITE: begin
					c_q   <= c_new;
					num_q <= num_q + NUM_W'(65536);
					if (j_q == TW'(T)) begin
						state_q <= W_IDLE;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= W_MUL;
					end
				end
				W_IDLE: begin
					state_q <= W_IDLE;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/flif_dp.sv =====
// ----------------------------------------------------------------------------
// flif_dp
// neuron datapath: history line, weight table, shared multiply-accumulate,
// neuron state and output register
// ----------------------------------------------------------------------------
`default_nettype none

module flif_dp #(
	parameter int HISTORY_DEPTH = flif_pkg::HIST_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire flif_pkg::dp_cmd_t                    cmd,
	input  wire logic [$clog2(HISTORY_DEPTH)-1:0]     idx,
	input  wire logic signed [flif_pkg::DATA_W-1:0]   input_current,
	input  wire logic [30:0]                          leak_gain,
	input  wire logic [30:0]                          input_gain,
	input  wire logic signed [flif_pkg::DATA_W-1:0]   rest_potential,
	input  wire logic signed [flif_pkg::DATA_W-1:0]   fire_threshold,
	input  wire logic signed [flif_pkg::DATA_W-1:0]   reset_potential,
	input  wire logic [15:0]                          refractory_steps,
	input  wire logic                                 w_we,
	input  wire logic [$clog2(HISTORY_DEPTH)-1:0]     w_addr,
	input  wire logic signed [flif_pkg::DATA_W-1:0]   w_data,
	output flif_pkg::dp_stat_t                        stat,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [flif_pkg::DATA_W-1:0]        membrane_potential,
	output logic                                      spike_fired
);

	localparam int T   = HISTORY_DEPTH - 1;
	localparam int TW  = $clog2(HISTORY_DEPTH);
	localparam int DW  = flif_pkg::DATA_W;
	localparam int AW  = flif_pkg::ACC_W;
	localparam int PW  = flif_pkg::PROD_W;

	logic signed [DW-1:0] hist_mem [T];
	logic signed [DW-1:0] w_mem [T];

	logic signed [DW-1:0] cur_q;
	logic signed [DW-1:0] pot_q;
	logic [15:0]          cnt_q;
	logic [TW-1:0]        head_q;
	logic [TW-1:0]        fill_q;

	logic signed [DW-1:0] hist_rd_s1;
	logic signed [DW-1:0] w_rd_s1;
	logic                 hvalid_s1;
	logic [1:0]           kind_s1;
	logic                 valid_s1;
	logic [PW-1:0]        prod_s2;
	logic                 neg_s2;
	logic                 sh30_s2;
	logic                 valid_s2;
	logic signed [AW-1:0] term_s3;
	logic                 valid_s3;
	logic signed [AW-1:0] acc_q;

	logic signed [DW-1:0] res_v_q;
	logic                 res_s_q;
	logic                 out_valid_q;
	logic signed [DW-1:0] out_pot_q;
	logic                 out_spk_q;

	logic [TW-1:0]        head_nx;
	logic [TW:0]          raddr_w;
	logic [TW-1:0]        raddr;
	logic signed [32:0]   opa;
	logic signed [32:0]   opb;
	logic [32:0]          mag_a;
	logic [31:0]          mag_b;
	logic [PW:0]          rsum;
	logic [PW:0]          rsh;
	logic signed [AW-1:0] rmag;
	logic signed [DW-1:0] v_sat;
	logic                 fire;
	logic [15:0]          cnt_inc;

	assign head_nx = (head_q == TW'(T - 1)) ? '0 : head_q + 1'b1;
	// entry idx counts back from the newest
	assign raddr_w = (idx <= head_q) ? ({1'b0, head_q} - {1'b0, idx})
		: ({1'b0, head_q} + (TW+1)'(T) - {1'b0, idx});
	assign raddr   = raddr_w[TW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.hist_push) begin
			hist_mem[head_nx] <= pot_q;
		end
		hist_rd_s1 <= hist_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[w_addr] <= w_data;
		end
		w_rd_s1 <= w_mem[idx];
	end

	// operand select and magnitude multiply
	always_comb begin
		case (kind_s1)
			flif_pkg::KIND_INPUT: begin
				opa = {cur_q[DW-1], cur_q};
				opb = {2'b00, input_gain};
			end
			flif_pkg::KIND_LEAK: begin
				opa = {pot_q[DW-1], pot_q} - {rest_potential[DW-1], rest_potential};
				opb = {2'b00, leak_gain};
			end
			default: begin
				opa = hvalid_s1 ? {hist_rd_s1[DW-1], hist_rd_s1} : '0;
				opb = {w_rd_s1[DW-1], w_rd_s1};
			end
		endcase
		mag_a = opa[32] ? 33'(-opa) : 33'(opa);
		mag_b = opb[32] ? 32'(-opb) : opb[31:0];
	end

	// round half away from zero on the magnitude
	always_comb begin
		if (sh30_s2) begin
			rsum = {1'b0, prod_s2} + (PW+1)'(1 << 29);
			rsh  = rsum >> 30;
		end else begin
			rsum = {1'b0, prod_s2} + (PW+1)'(1 << 15);
			rsh  = rsum >> 16;
		end
		rmag = signed'(rsh[AW-1:0]);
	end

	assign v_sat   = flif_pkg::sat_data(acc_q);
	assign fire    = (v_sat >= fire_threshold);
	assign cnt_inc = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		hvalid_s1 <= (idx < fill_q);
		kind_s1   <= cmd.kind;
		prod_s2   <= PW'(mag_a) * PW'(mag_b);
		neg_s2    <= opa[32] ^ opb[32] ^ (kind_s1 != flif_pkg::KIND_INPUT);
		sh30_s2   <= (kind_s1 == flif_pkg::KIND_HIST);
		term_s3   <= neg_s2 ? -rmag : rmag;
		if (cmd.in_load) begin
			cur_q <= input_current;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pot_q       <= flif_pkg::RPOT_RST;
			cnt_q       <= 16'hFFFF;
			head_q      <= '0;
			fill_q      <= '0;
			res_v_q     <= '0;
			res_s_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_pot_q   <= '0;
			out_spk_q   <= 1'b0;
		end else begin
			if (cmd.acc_clear) begin
				acc_q <= '0;
			end else if (valid_s3) begin
				acc_q <= acc_q + term_s3;
			end
			if (cmd.hist_push) begin
				head_q <= head_nx;
				if (fill_q != TW'(T)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.commit_step) begin
				if (fire) begin
					pot_q   <= reset_potential;
					res_v_q <= reset_potential;
					res_s_q <= 1'b1;
					cnt_q   <= 16'd1;
				end else begin
					pot_q   <= v_sat;
					res_v_q <= v_sat;
					res_s_q <= 1'b0;
					cnt_q   <= cnt_inc;
				end
			end else if (cmd.commit_refr) begin
				pot_q   <= reset_potential;
				res_v_q <= reset_potential;
				res_s_q <= 1'b0;
				cnt_q   <= cnt_inc;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				out_pot_q   <= res_v_q;
				out_spk_q   <= res_s_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.refractory  = !(cnt_q > refractory_steps);
	assign stat.out_free    = !out_valid_q || !out_stall;
	assign out_valid          = out_valid_q;
	assign membrane_potential = out_pot_q;
	assign spike_fired        = out_spk_q;

endmodule

`default_nettype wire

// ===== design/flif_ctrl.sv =====
// ----------------------------------------------------------------------------
// flif_ctrl
// step sequencer: accepts an item, walks the history taps, commits the step
// ----------------------------------------------------------------------------
`default_nettype none

module flif_ctrl #(
	parameter int HISTORY_DEPTH = flif_pkg::HIST_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              wgen_busy,
	input  wire logic [8:0]                        hist_len,
	input  wire flif_pkg::dp_stat_t                stat,
	output flif_pkg::dp_cmd_t                      cmd,
	output logic [$clog2(HISTORY_DEPTH)-1:0]       idx
);

	localparam int T  = HISTORY_DEPTH - 1;
	localparam int TW = $clog2(HISTORY_DEPTH);
	localparam int LW = (TW + 1 > 9) ? TW + 1 : 9;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_REFR  = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_LEAK  = 3'd3;
	localparam logic [2:0] S_MAC   = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_FINAL = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [TW-1:0] idx_q;
	logic [1:0]    drain_q;
	logic [LW-1:0] len_e;
	logic [TW-1:0] ntaps;
	logic          in_acc;

	// taps in use, clamped to the line
	always_comb begin
		len_e = LW'(hist_len);
		if (len_e < LW'(2)) begin
			ntaps = TW'(1);
		end else if (len_e > LW'(HISTORY_DEPTH)) begin
			ntaps = TW'(T);
		end else begin
			ntaps = TW'(len_e - LW'(1));
		end
	end

	assign in_stall = !((state_q == S_IDLE) && !wgen_busy);
	assign in_acc   = in_valid && !in_stall;
	assign idx      = idx_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd.in_load = 1'b1;
					state_d     = stat.refractory ? S_REFR : S_START;
				end
			end
			S_REFR: begin
				cmd.commit_refr = 1'b1;
				state_d         = S_OUT;
			end
			S_START: begin
				cmd.hist_push = 1'b1;
				cmd.acc_clear = 1'b1;
				cmd.issue     = 1'b1;
				cmd.kind      = flif_pkg::KIND_INPUT;
				state_d       = S_LEAK;
			end
			S_LEAK: begin
				cmd.issue = 1'b1;
				cmd.kind  = flif_pkg::KIND_LEAK;
				state_d   = S_MAC;
			end
			S_MAC: begin
				cmd.issue = 1'b1;
				cmd.kind  = flif_pkg::KIND_HIST;
				if (idx_q == ntaps - 1'b1) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (drain_q == 2'd2) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				cmd.commit_step = 1'b1;
				state_d         = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LEAK) begin
				idx_q <= '0;
			end else if (state_q == S_MAC) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == S_DRAIN) begin
				drain_q <= drain_q + 1'b1;
			end else begin
				drain_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/fractional_lif_neuron_step_top.sv =====
// ----------------------------------------------------------------------------
// fractional_lif_neuron_step_top
// fractional-order leaky integrate-and-fire neuron, one time step per item
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry one input_current sample per
//   time step. output channel: out_valid / out_stall carry the membrane
//   potential after the step and the one-step spike flag.
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data.
//   an item walks n = history_length - 1 history taps on the single shared
//   multiplier, one tap a cycle; a refractory step skips the taps.
//   one item is in work at a time, so a new transaction is taken only once
//   the result of the last one sits in the output register, even while it
//   waits there.
//   reset and every alpha write rebuild the weight table, and while that
//   runs in_stall and cfg_ready hold the block off.
//   a stalled output keeps its result and the block waits with the next
//   finished step until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fractional_lif_neuron_step_top_macros.svh"

module fractional_lif_neuron_step_top #(
	parameter int HISTORY_DEPTH = flif_pkg::HIST_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [flif_pkg::DATA_W-1:0]   input_current,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [flif_pkg::DATA_W-1:0]        membrane_potential,
	output logic                                      spike_fired,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [flif_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [flif_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int TW = $clog2(HISTORY_DEPTH);

	// configuration registers
	logic [16:0]                          alpha_q;
	logic [8:0]                           hlen_q;
	logic [30:0]                          leak_q;
	logic [30:0]                          ingn_q;
	logic signed [flif_pkg::DATA_W-1:0]   rest_q;
	logic signed [flif_pkg::DATA_W-1:0]   thr_q;
	logic signed [flif_pkg::DATA_W-1:0]   rpot_q;
	logic [15:0]                          refr_q;

	logic                                 cfg_acc;
	logic                                 wgen_start;
	logic                                 wgen_busy;
	logic [16:0]                          alpha_eff;
	logic                                 w_we;
	logic [TW-1:0]                        w_addr;
	logic signed [flif_pkg::DATA_W-1:0]   w_data;
	flif_pkg::dp_cmd_t                    cmd;
	flif_pkg::dp_stat_t                   stat;
	logic [TW-1:0]                        idx;

	// config transactions are held off while the weight table is rebuilt
	assign cfg_ready  = !wgen_busy;
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign wgen_start = cfg_acc && (cfg_index == flif_pkg::REG_ALPHA);
	// alpha above one acts as one
	assign alpha_eff  = (alpha_q > flif_pkg::ALPHA_ONE) ? flif_pkg::ALPHA_ONE : alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= flif_pkg::ALPHA_RST;
			hlen_q  <= flif_pkg::HLEN_RST;
			leak_q  <= flif_pkg::LEAK_RST;
			ingn_q  <= flif_pkg::INGN_RST;
			rest_q  <= flif_pkg::REST_RST;
			thr_q   <= flif_pkg::THR_RST;
			rpot_q  <= flif_pkg::RPOT_RST;
			refr_q  <= flif_pkg::REFR_RST;
		end else if (cfg_acc) begin
			case (cfg_index)
				flif_pkg::REG_ALPHA: alpha_q <= cfg_data[16:0];
				flif_pkg::REG_HLEN:  hlen_q  <= cfg_data[8:0];
				flif_pkg::REG_LEAK:  leak_q  <= cfg_data[30:0];
				flif_pkg::REG_INGN:  ingn_q  <= cfg_data[30:0];
				flif_pkg::REG_REST:  rest_q  <= signed'(cfg_data);
				flif_pkg::REG_THR:   thr_q   <= signed'(cfg_data);
				flif_pkg::REG_RPOT:  rpot_q  <= signed'(cfg_data);
				flif_pkg::REG_REFR:  refr_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// weight table builder, runs out of reset and after every alpha write
	flif_wgen #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_wgen (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wgen_start),
		.alpha  (alpha_eff),
		.busy   (wgen_busy),
		.w_we   (w_we),
		.w_addr (w_addr),
		.w_data (w_data)
	);

	// step sequencer
	flif_ctrl #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.wgen_busy (wgen_busy),
		.hist_len  (hlen_q),
		.stat      (stat),
		.cmd       (cmd),
		.idx       (idx)
	);

	// history line, weights, multiply-accumulate and output register
	flif_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.idx                (idx),
		.input_current      (input_current),
		.leak_gain          (leak_q),
		.input_gain         (ingn_q),
		.rest_potential     (rest_q),
		.fire_threshold     (thr_q),
		.reset_potential    (rpot_q),
		.refractory_steps   (refr_q),
		.w_we               (w_we),
		.w_addr             (w_addr),
		.w_data             (w_data),
		.stat               (stat),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.membrane_potential (membrane_potential),
		.spike_fired        (spike_fired)
	);

	// no input transaction while weights are being rebuilt
	`FLIF_ASSERT_IMP(a_no_input_in_build, clk, arst_n, wgen_busy, in_stall, "input taken during weight build")
	// one item in work at a time
	`FLIF_ASSERT_NXT(a_one_item, clk, arst_n, in_valid && !in_stall, in_stall, "second item taken while busy")
	// an alpha write always starts a rebuild
	`FLIF_ASSERT_NXT(a_alpha_rebuild, clk, arst_n, cfg_valid && cfg_ready && cfg_index == flif_pkg::REG_ALPHA, wgen_busy, "alpha write did not start weight build")

endmodule

`default_nettype wire
